### design/dqs_pkg.sv
// Shared types, codes and defaults for the double-ended queue with linear search.
package dqs_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int CMD_QUEUE_DEPTH = 2;
  localparam int RES_QUEUE_DEPTH = 2;

  // Request mode codes as they arrive on the input word.
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
  localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [2:0] MODE_POP_BACK   = 3'd3;
  localparam logic [2:0] MODE_SEARCH     = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_SEARCH,
    OP_NONE
  } op_t;

  typedef enum logic {
    BK_IDLE,
    BK_SEARCH
  } bk_state_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic       found;
    logic [3:0] position;
    logic [4:0] occupancy;
  } rsp_t;

  typedef struct packed {
    op_t                op;
    logic signed [31:0] value;
  } cmd_t;

endpackage

### design/dqs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/dqs_fifo.sv
// Small synchronous FIFO used between the front, the back and the result port.
module dqs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             wr_ok;
  logic             rd_ok;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign wr_ok   = wr_en && !full;
  assign rd_ok   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_ok) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd_ok) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (wr_ok && !rd_ok) begin
        count <= count + CW'(1);
      end else if (rd_ok && !wr_ok) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

### design/dqs_front.sv
// Front end: takes request words, decodes the mode and queues commands for the back end.
module dqs_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  dqs_pkg::req_t req,
  input  logic          cmd_pop,
  output dqs_pkg::cmd_t cmd,
  output logic          cmd_empty
);

  dqs_pkg::cmd_t cmd_in;

  // Modes outside the defined set become a no-op that still yields a result.
  always_comb begin
    cmd_in.value = req.value;
    case (req.mode)
      dqs_pkg::MODE_PUSH_FRONT: cmd_in.op = dqs_pkg::OP_PUSH_FRONT;
      dqs_pkg::MODE_PUSH_BACK:  cmd_in.op = dqs_pkg::OP_PUSH_BACK;
      dqs_pkg::MODE_POP_FRONT:  cmd_in.op = dqs_pkg::OP_POP_FRONT;
      dqs_pkg::MODE_POP_BACK:   cmd_in.op = dqs_pkg::OP_POP_BACK;
      dqs_pkg::MODE_SEARCH:     cmd_in.op = dqs_pkg::OP_SEARCH;
      default:                  cmd_in.op = dqs_pkg::OP_NONE;
    endcase
  end

  dqs_fifo #(
    .WIDTH ($bits(dqs_pkg::cmd_t)),
    .DEPTH (dqs_pkg::CMD_QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (cmd_in),
    .full    (full),
    .rd_en   (cmd_pop),
    .rd_data (cmd),
    .empty   (cmd_empty)
  );

endmodule

### design/dqs_back.sv
// Back end: owns the circular store, executes commands and queues result words.
module dqs_back #(
  parameter int DEPTH = dqs_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_empty,
  input  dqs_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          pop,
  output dqs_pkg::rsp_t rsp,
  output logic          empty
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  dqs_pkg::bk_state_t state, state_next;

  logic [AW-1:0]      front_index, front_next;
  logic [CW-1:0]      stored_count, count_next;
  logic [AW-1:0]      ptr, ptr_next;
  logic [CW-1:0]      idx, idx_next;
  logic signed [31:0] key, key_next;

  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [31:0]        rd_data;

  logic               res_push;
  logic               res_full;
  dqs_pkg::rsp_t      res_word;

  logic [AW-1:0]      front_inc;
  logic [AW-1:0]      front_dec;
  logic [AW-1:0]      ptr_inc;
  logic [CW:0]        back_sum;
  logic [AW-1:0]      back_slot;
  logic [CW-1:0]      idx_inc;
  logic [CW+4:0]      occ_wide;
  logic [CW+3:0]      pos_wide;

  assign front_inc = (front_index == AW'(DEPTH - 1)) ? '0 : front_index + AW'(1);
  assign front_dec = (front_index == '0) ? AW'(DEPTH - 1) : front_index - AW'(1);
  assign ptr_inc   = (ptr == AW'(DEPTH - 1)) ? '0 : ptr + AW'(1);
  assign idx_inc   = idx + CW'(1);

  // Slot behind the last word; the sum stays below twice the depth.
  always_comb begin
    back_sum = (CW+1)'(front_index) + (CW+1)'(stored_count);
    if (back_sum >= (CW+1)'(DEPTH)) begin
      back_sum = back_sum - (CW+1)'(DEPTH);
    end
    back_slot = back_sum[AW-1:0];
  end

  assign occ_wide = {5'b0, count_next};
  assign pos_wide = {4'b0, idx};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= dqs_pkg::BK_IDLE;
      front_index  <= '0;
      stored_count <= '0;
    end else begin
      state        <= state_next;
      front_index  <= front_next;
      stored_count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    idx <= idx_next;
    key <= key_next;
  end

  always_comb begin
    state_next = state;
    front_next = front_index;
    count_next = stored_count;
    ptr_next   = ptr;
    idx_next   = idx;
    key_next   = key;
    cmd_pop    = 1'b0;
    wr_en      = 1'b0;
    wr_addr    = front_dec;
    rd_en      = 1'b0;
    rd_addr    = front_index;
    res_push   = 1'b0;
    res_word   = '0;

    case (state)
      dqs_pkg::BK_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            dqs_pkg::OP_PUSH_FRONT: begin
              res_push = 1'b1;
              if (stored_count == CW'(DEPTH)) begin
                res_word.status = dqs_pkg::ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = front_dec;
                front_next = front_dec;
                count_next = stored_count + CW'(1);
              end
            end
            dqs_pkg::OP_PUSH_BACK: begin
              res_push = 1'b1;
              if (stored_count == CW'(DEPTH)) begin
                res_word.status = dqs_pkg::ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = back_slot;
                count_next = stored_count + CW'(1);
              end
            end
            dqs_pkg::OP_POP_FRONT: begin
              res_push = 1'b1;
              if (stored_count == '0) begin
                res_word.status = dqs_pkg::ST_EMPTY;
              end else begin
                front_next = front_inc;
                count_next = stored_count - CW'(1);
              end
            end
            dqs_pkg::OP_POP_BACK: begin
              res_push = 1'b1;
              if (stored_count == '0) begin
                res_word.status = dqs_pkg::ST_EMPTY;
              end else begin
                count_next = stored_count - CW'(1);
              end
            end
            dqs_pkg::OP_SEARCH: begin
              if (stored_count == '0) begin
                res_push = 1'b1;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = front_index;
                ptr_next   = front_index;
                idx_next   = '0;
                key_next   = cmd.value;
                state_next = dqs_pkg::BK_SEARCH;
              end
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end
      dqs_pkg::BK_SEARCH: begin
        // Compare the word read last cycle while fetching the next one.
        rd_en   = 1'b1;
        rd_addr = ptr_inc;
        if (rd_data == key) begin
          res_push          = 1'b1;
          res_word.found    = 1'b1;
          res_word.position = pos_wide[3:0];
          state_next        = dqs_pkg::BK_IDLE;
        end else if (idx_inc == stored_count) begin
          res_push   = 1'b1;
          state_next = dqs_pkg::BK_IDLE;
        end else begin
          idx_next = idx_inc;
          ptr_next = ptr_inc;
        end
      end
      default: begin
        state_next = dqs_pkg::BK_IDLE;
      end
    endcase

    res_word.occupancy = occ_wide[4:0];
  end

  dqs_ram #(
    .WIDTH (32),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (cmd.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  dqs_fifo #(
    .WIDTH ($bits(dqs_pkg::rsp_t)),
    .DEPTH (dqs_pkg::RES_QUEUE_DEPTH)
  ) u_res_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_word),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (rsp),
    .empty   (empty)
  );

endmodule

### design/deque_with_linear_search.sv
// Top level of the bounded double-ended queue with linear search.
//
// Requests enter as words on a queue-style port: a word is taken at a clock
// edge where push is high and full is low. Each word carries a mode (push
// front, push back, pop front, pop back, search) and a 32-bit value. Every
// request yields exactly one result word, presented in request order on a
// second queue-style port: the oldest result is shown while empty is low and
// leaves at an edge where pop is high.
//
// A push, pop or undefined mode passes from the command queue to the back
// end, which executes it in its idle state and writes its result into the
// result queue; such requests stream at one per cycle while the result
// queue has room and no search is running. A search walks the store one
// word per cycle through the store RAM's single read port, starting at the
// front: it first reads the front word, then compares each word read while
// fetching the next, and ends on the first match or the last stored word.
//
// Reset (rst, synchronous) empties the store and both internal queues. When
// the receiver stalls, results collect in a two-word result queue; once it
// fills, the back end holds, the two-word command queue fills and full rises.
module deque_with_linear_search #(
  parameter int DEPTH = dqs_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  dqs_pkg::req_t req,
  output logic          empty,
  input  logic          pop,
  output dqs_pkg::rsp_t rsp
);

  // Decoded commands waiting between the front end and the back end.
  dqs_pkg::cmd_t cmd;
  logic          cmd_empty;
  logic          cmd_pop;

  dqs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req       (req),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  // The back end holds the circular store, its front index and word count,
  // and the search sequencer.
  dqs_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .rsp       (rsp),
    .empty     (empty)
  );

endmodule

### design/dqs_checker.sv
// Port-level checker for the double-ended queue, bound to the top level.
module dqs_checker (
  input logic          clk,
  input logic          rst,
  input logic          full,
  input logic          empty,
  input logic          pop,
  input dqs_pkg::rsp_t rsp
);

  // Reset drains every queue and reopens the request port.
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not cleared after reset");

  // A found key can only come from a search, which always reports done.
  a_found_done: assert property (@(posedge clk) disable iff (rst)
    (!empty && rsp.found) |-> (rsp.status == dqs_pkg::ST_DONE))
    else $error("found flag with a non-done status");

  // Without a match the position reads zero.
  a_miss_position: assert property (@(posedge clk) disable iff (rst)
    (!empty && !rsp.found) |-> (rsp.position == 4'd0))
    else $error("nonzero position without a match");

  // A result that is not taken stays in place.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(rsp)))
    else $error("result changed while stalled");

endmodule

bind deque_with_linear_search dqs_checker u_dqs_checker (
  .clk   (clk),
  .rst   (rst),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .rsp   (rsp)
);

### tb/sv/tb_deque_with_linear_search.sv
// Self-checking testbench for the double-ended queue with linear search.
module tb_deque_with_linear_search;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = dqs_pkg::DEPTH_DEFAULT;

  // Modes 5 to 7 carry no operation; the block must ignore them.
  localparam logic [2:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] MODE_SPARE_LAST  = 3'd7;

  localparam int RANDOM_WORDS = 750;
  // Once this few request words are left to send, neither side idles.
  localparam int CALM_TAIL = 60;
  // A search compares at most DEPTH words and the idle gaps on both sides
  // are limited, so even the slowest correct run stays far below this.
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 40;

  // A request word waiting to be sent. When hold_for_drain is set, the
  // driver does not send it until every expected result has come back.
  typedef struct {
    dqs_pkg::req_t w;
    bit            hold_for_drain;
  } pending_req_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          push = 1'b0;
  logic          pop = 1'b0;
  dqs_pkg::req_t req = '0;
  logic          full;
  logic          empty;
  dqs_pkg::rsp_t rsp;

  deque_with_linear_search #(
    .DEPTH(DEPTH)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .req  (req),
    .empty(empty),
    .pop  (pop),
    .rsp  (rsp)
  );

  always #1 clk = ~clk;

  pending_req_t  request_backlog[$];
  dqs_pkg::rsp_t expected_rsp[$];
  int            mismatch_count = 0;
  int            cycle_count = 0;

  // Shadow copy of the deque. The store is a ring addressed from shadow_head,
  // and shadow_fill words starting there are valid.
  logic signed [31:0] shadow_store[DEPTH];
  int                 shadow_head = 0;
  int                 shadow_fill = 0;

  // Applies one request to the shadow deque and returns the result word the
  // block must produce for it.
  function automatic dqs_pkg::rsp_t deque_predict(dqs_pkg::req_t w);
    dqs_pkg::rsp_t r;
    int            i;
    r = '0;
    r.status = dqs_pkg::ST_DONE;
    case (w.mode)
      dqs_pkg::MODE_PUSH_FRONT: begin
        if (shadow_fill >= DEPTH) begin
          r.status = dqs_pkg::ST_FULL;
        end else begin
          shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
          shadow_store[shadow_head] = w.value;
          shadow_fill++;
        end
      end
      dqs_pkg::MODE_PUSH_BACK: begin
        if (shadow_fill >= DEPTH) begin
          r.status = dqs_pkg::ST_FULL;
        end else begin
          shadow_store[(shadow_head + shadow_fill) % DEPTH] = w.value;
          shadow_fill++;
        end
      end
      dqs_pkg::MODE_POP_FRONT: begin
        if (shadow_fill == 0) begin
          r.status = dqs_pkg::ST_EMPTY;
        end else begin
          shadow_head = (shadow_head + 1) % DEPTH;
          shadow_fill--;
        end
      end
      dqs_pkg::MODE_POP_BACK: begin
        if (shadow_fill == 0) begin
          r.status = dqs_pkg::ST_EMPTY;
        end else begin
          shadow_fill--;
        end
      end
      dqs_pkg::MODE_SEARCH: begin
        // Only valid words are compared, so entries never written are never
        // looked at. The first match from the front wins.
        for (i = 0; i < shadow_fill; i++) begin
          if (!r.found && shadow_store[(shadow_head + i) % DEPTH] == w.value) begin
            r.found = 1'b1;
            r.position = i[3:0];
          end
        end
      end
      default: begin
      end
    endcase
    r.occupancy = shadow_fill[4:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Driver. An item is taken at an edge where push is high and full is low;
  // the shadow deque is advanced at exactly that edge. The next word is only
  // put up once the current one has been taken, so push and req are each
  // assigned at most once per edge.
  // ---------------------------------------------------------------------
  int send_gap = 0;
  int send_window = 0;
  bit send_idle_on = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expected_rsp.insert(expected_rsp.size(), deque_predict(req));
      end
      // Idling comes and goes in windows so that some stretches run back to
      // back and others are full of gaps.
      if (send_window == 0) begin
        send_window = $urandom_range(20, 80);
        send_idle_on = ($urandom_range(0, 2) != 0);
      end else begin
        send_window--;
      end
      if (push && full) begin
        // The word on the port has not been taken yet; keep it there.
      end else if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (request_backlog.size() == 0) begin
        push <= 1'b0;
      end else if (request_backlog[0].hold_for_drain && expected_rsp.size() != 0) begin
        // Hold off until the block has handed back everything it owes.
        push <= 1'b0;
      end else if (send_idle_on && request_backlog.size() > CALM_TAIL &&
                   $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(1, 10) - 1;
        push <= 1'b0;
      end else begin
        req  <= request_backlog[0].w;
        push <= 1'b1;
        request_backlog.delete(0);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor. A result word is taken at an edge where pop is high and empty
  // is low, and is compared field by field with the oldest expectation.
  // ---------------------------------------------------------------------
  int recv_gap = 0;
  int recv_window = 0;
  bit recv_idle_on = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_rsp.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("%0t: result word with none expected:", $realtime,
                     " status %0d found %0d position %0d occupancy %0d",
                     rsp.status, rsp.found, rsp.position, rsp.occupancy);
          end
          mismatch_count++;
        end else begin
          dqs_pkg::rsp_t want;
          want = expected_rsp[0];
          expected_rsp.delete(0);
          if (rsp.status !== want.status || rsp.found !== want.found ||
              rsp.position !== want.position || rsp.occupancy !== want.occupancy) begin
            if (mismatch_count < 10) begin
              $display("%0t: result mismatch: expected", $realtime,
                       " status %0d found %0d position %0d occupancy %0d,",
                       want.status, want.found, want.position, want.occupancy,
                       " got status %0d found %0d position %0d occupancy %0d",
                       rsp.status, rsp.found, rsp.position, rsp.occupancy);
            end
            mismatch_count++;
          end
        end
      end
      if (recv_window == 0) begin
        recv_window = $urandom_range(20, 80);
        recv_idle_on = ($urandom_range(0, 2) != 0);
      end else begin
        recv_window--;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        pop <= 1'b0;
      end else if (recv_idle_on && request_backlog.size() > CALM_TAIL &&
                   $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(1, 10) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: a hung block or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_deque_with_linear_search NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------
  logic signed [31:0] word_pool[8];
  logic signed [31:0] pushed_history[$];

  task automatic queue_request(logic [2:0] mode, logic signed [31:0] value, bit hold);
    pending_req_t p;
    p.w.mode = mode;
    p.w.value = value;
    p.hold_for_drain = hold;
    request_backlog.insert(request_backlog.size(), p);
    if (mode == dqs_pkg::MODE_PUSH_FRONT || mode == dqs_pkg::MODE_PUSH_BACK) begin
      pushed_history.insert(pushed_history.size(), value);
      if (pushed_history.size() > 32) begin
        pushed_history.delete(0);
      end
    end
  endtask

  // Words to push: often from a small pool so that duplicates build up and
  // searches must pick the first match, otherwise fully random.
  function automatic logic signed [31:0] pick_word();
    if ($urandom_range(0, 9) < 4) begin
      return word_pool[$urandom_range(0, 7)];
    end
    return $urandom;
  endfunction

  // Keys to search: mostly words pushed lately, so hits land at all depths.
  function automatic logic signed [31:0] pick_key();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5 && pushed_history.size() != 0) begin
      return pushed_history[$urandom_range(0, pushed_history.size() - 1)];
    end else if (pick < 8) begin
      return word_pool[$urandom_range(0, 7)];
    end
    return $urandom;
  endfunction

  // Random traffic in segments that lean toward filling, draining or
  // neither, so the store keeps swinging between empty and full.
  task automatic queue_random_traffic(int count);
    int n;
    int seg_left;
    int push_pct;
    int pop_pct;
    int roll;
    bit hold;
    seg_left = 0;
    push_pct = 35;
    pop_pct = 35;
    for (n = 0; n < count; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(10, 40);
        case ($urandom_range(0, 2))
          0: begin push_pct = 70; pop_pct = 15; end
          1: begin push_pct = 15; pop_pct = 70; end
          default: begin push_pct = 35; pop_pct = 35; end
        endcase
      end
      seg_left--;
      hold = (n == 0 || n == count / 3 || n == (2 * count) / 3);
      roll = $urandom_range(0, 99);
      if (roll < push_pct) begin
        queue_request($urandom_range(0, 1) ? dqs_pkg::MODE_PUSH_BACK
                                           : dqs_pkg::MODE_PUSH_FRONT,
                      pick_word(), hold);
      end else if (roll < push_pct + pop_pct) begin
        // The value of a pop is ignored, but it still gets random bits.
        queue_request($urandom_range(0, 1) ? dqs_pkg::MODE_POP_BACK
                                           : dqs_pkg::MODE_POP_FRONT,
                      $urandom, hold);
      end else if (roll < 97) begin
        queue_request(dqs_pkg::MODE_SEARCH, pick_key(), hold);
      end else begin
        queue_request(3'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST)),
                      $urandom, hold);
      end
    end
  endtask

  initial begin
    logic signed [31:0] deep_word;
    int k;

    word_pool[0] = 32'sh8000_0000;
    word_pool[1] = 32'sh7fff_ffff;
    word_pool[2] = 32'sh0000_0000;
    word_pool[3] = -32'sd1;
    for (k = 4; k < 8; k++) begin
      word_pool[k] = $urandom;
    end

    // Directed part. On the empty store: pops from both ends are refused,
    // a search misses and spare modes change nothing.
    queue_request(dqs_pkg::MODE_POP_FRONT, 32'sh0, 1'b0);
    queue_request(dqs_pkg::MODE_POP_BACK, -32'sd1, 1'b0);
    queue_request(dqs_pkg::MODE_SEARCH, 32'sh0, 1'b0);
    queue_request(MODE_SPARE_FIRST, 32'sh7fff_ffff, 1'b0);
    queue_request(MODE_SPARE_LAST, 32'sh8000_0000, 1'b0);
    // Extreme words at both ends, then fill up to capacity from the back.
    queue_request(dqs_pkg::MODE_PUSH_FRONT, 32'sh8000_0000, 1'b0);
    queue_request(dqs_pkg::MODE_PUSH_BACK, 32'sh7fff_ffff, 1'b0);
    queue_request(dqs_pkg::MODE_PUSH_BACK, -32'sd1, 1'b0);
    queue_request(dqs_pkg::MODE_PUSH_FRONT, 32'sh0, 1'b0);
    deep_word = '0;
    for (k = 0; k < DEPTH - 4; k++) begin
      deep_word = $urandom;
      queue_request(dqs_pkg::MODE_PUSH_BACK, deep_word, 1'b0);
    end
    // A full store refuses pushes at either end.
    queue_request(dqs_pkg::MODE_PUSH_FRONT, 32'sh1234_5678, 1'b0);
    queue_request(dqs_pkg::MODE_PUSH_BACK, -32'sd2, 1'b0);
    // Hits in the middle and at the very back, and one likely miss.
    queue_request(dqs_pkg::MODE_SEARCH, 32'sh7fff_ffff, 1'b0);
    queue_request(dqs_pkg::MODE_SEARCH, deep_word, 1'b0);
    queue_request(dqs_pkg::MODE_SEARCH, $urandom, 1'b0);

    queue_random_traffic(RANDOM_WORDS);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Everything sent and taken, then everything returned, then a short
    // settle so that a stray extra result word would still be caught.
    while (request_backlog.size() != 0 || push == 1'b1) begin
      @(posedge clk);
    end
    while (expected_rsp.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && expected_rsp.size() == 0) begin
      $display("tb_deque_with_linear_search OK");
    end else begin
      $display("tb_deque_with_linear_search NOT OK");
    end
    $finish;
  end

endmodule
